>>> sv/segment_box_hit_test_defines.svh
// ---------------------------------------------------------------------------
// Segment box hit test: assertion macros
// Shared property templates for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_BOX_HIT_TEST_DEFINES_SVH
`define SEGMENT_BOX_HIT_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SBHT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBHT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sbht_pkg.sv
// ---------------------------------------------------------------------------
// Segment box hit test: shared package
// Controller states and the command and status groups between the
// controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbht_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_A,
    ST_AQ,
    ST_MUL_OFF,
    ST_DIV_INC,
    ST_STEP_PREP,
    ST_MUL_STEP,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic set_vert;
    logic div_start;
    logic div_inc;
    logic div_step;
    logic take_aq;
    logic take_inc;
    logic mul_start;
    logic mul_inc;
    logic mul_step;
    logic take_off;
    logic take_step;
    logic walk_step;
    logic set_hit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic vertical;
    logic x_rev;
    logic need_inc;
    logic seq_done;
    logic in_range;
    logic point_hit;
  } status_t;

endpackage

>>> sv/sbht_ctrl.sv
// ---------------------------------------------------------------------------
// Segment box hit test: controller
// Sequences setup (slope division, offset and step products), the sample
// walk, and the hand-off of the answer to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbht_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sbht_pkg::status_t status,
  output sbht_pkg::cmd_t    cmd
);

  sbht_pkg::state_t state;
  sbht_pkg::state_t state_next;
  logic             out_valid_next;
  logic             slot_free;

  assign in_ready  = (state == sbht_pkg::ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbht_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sbht_pkg::ST_IDLE: begin
        if (in_valid) state_next = sbht_pkg::ST_CHECK;
      end
      sbht_pkg::ST_CHECK: begin
        state_next = status.vertical ? sbht_pkg::ST_FINISH : sbht_pkg::ST_DIV_A;
      end
      sbht_pkg::ST_DIV_A: begin
        if (status.seq_done) state_next = sbht_pkg::ST_AQ;
      end
      sbht_pkg::ST_AQ: begin
        if (status.x_rev) state_next = sbht_pkg::ST_MUL_OFF;
        else if (status.need_inc) state_next = sbht_pkg::ST_DIV_INC;
        else state_next = sbht_pkg::ST_STEP_PREP;
      end
      sbht_pkg::ST_MUL_OFF: begin
        if (status.seq_done) begin
          state_next = status.need_inc ? sbht_pkg::ST_DIV_INC : sbht_pkg::ST_STEP_PREP;
        end
      end
      sbht_pkg::ST_DIV_INC: begin
        if (status.seq_done) state_next = sbht_pkg::ST_STEP_PREP;
      end
      sbht_pkg::ST_STEP_PREP: begin
        state_next = sbht_pkg::ST_MUL_STEP;
      end
      sbht_pkg::ST_MUL_STEP: begin
        if (status.seq_done) state_next = sbht_pkg::ST_WALK;
      end
      sbht_pkg::ST_WALK: begin
        if (!status.in_range || status.point_hit) state_next = sbht_pkg::ST_FINISH;
      end
      sbht_pkg::ST_FINISH: begin
        if (slot_free) state_next = sbht_pkg::ST_IDLE;
      end
      default: begin
        state_next = sbht_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      sbht_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      sbht_pkg::ST_CHECK: begin
        cmd.set_vert  = status.vertical;
        cmd.div_start = !status.vertical;
      end
      sbht_pkg::ST_DIV_A: begin
        cmd.div_step = !status.seq_done;
        cmd.take_aq  = status.seq_done;
      end
      sbht_pkg::ST_AQ: begin
        cmd.mul_start = status.x_rev;
        cmd.div_start = !status.x_rev && status.need_inc;
        cmd.div_inc   = 1'b1;
      end
      sbht_pkg::ST_MUL_OFF: begin
        cmd.mul_step  = !status.seq_done;
        cmd.take_off  = status.seq_done;
        cmd.div_start = status.seq_done && status.need_inc;
        cmd.div_inc   = 1'b1;
      end
      sbht_pkg::ST_DIV_INC: begin
        cmd.div_step = !status.seq_done;
        cmd.take_inc = status.seq_done;
      end
      sbht_pkg::ST_STEP_PREP: begin
        cmd.mul_start = 1'b1;
        cmd.mul_inc   = 1'b1;
      end
      sbht_pkg::ST_MUL_STEP: begin
        cmd.mul_step  = !status.seq_done;
        cmd.take_step = status.seq_done;
      end
      sbht_pkg::ST_WALK: begin
        cmd.set_hit   = status.in_range && status.point_hit;
        cmd.walk_step = status.in_range && !status.point_hit;
      end
      sbht_pkg::ST_FINISH: begin
        cmd.out_load = slot_free;
        if (slot_free) out_valid_next = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> sv/sbht_datapath.sv
// ---------------------------------------------------------------------------
// Segment box hit test: datapath
// Widened rectangle, a shared restoring divider and shift-add multiplier,
// and the incremental x/y sample walk with its containment test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbht_datapath #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sbht_pkg::cmd_t               cmd,
  output sbht_pkg::status_t            status,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] box_left,
  input  logic signed [COORD_BITS-1:0] box_top,
  input  logic        [COORD_BITS-1:0] box_width,
  input  logic        [COORD_BITS-1:0] box_height,
  input  logic        [7:0]            pen_width,
  output logic                         hit
);

  localparam int CB      = COORD_BITS;
  localparam int FB      = FRAC_BITS;
  localparam int BW      = CB + 2;
  localparam int DW      = CB + 1;
  localparam int NW      = CB + FB;
  localparam int AW      = NW + 1;
  localparam int XW      = CB + FB + 1;
  localparam int YW_FULL = CB + 2 * FB + 3;
  // The y accumulator wraps the way a 64-bit sum does at the widest settings.
  localparam int YW      = (YW_FULL > 64) ? 64 : YW_FULL;
  localparam int PYW     = YW - 2 * FB;
  localparam int KW      = (BW > PYW) ? BW : PYW;
  localparam int MB      = (CB > FB + 1) ? CB : FB + 1;
  localparam int IW      = FB + 1;
  localparam int CNTW    = $clog2(NW + 1);

  localparam logic signed [XW-1:0] XHALF   = XW'(1) << (FB - 1);
  localparam logic        [YW-1:0] YHALF   = YW'(1) << (2 * FB - 1);
  localparam logic        [IW-1:0] INC_ONE = IW'(1) << FB;
  localparam logic signed [BW-1:0] ONE_B   = BW'(1);

  // Segment and rectangle captured at load.
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [BW-1:0] edge_l;
  logic signed [BW-1:0] edge_r;
  logic signed [BW-1:0] edge_t;
  logic signed [BW-1:0] edge_b;
  logic signed [BW-1:0] x1_b;
  logic signed [BW-1:0] ylo;
  logic signed [BW-1:0] yhi;

  // Divider.
  logic [CB-1:0] rem;
  logic [NW-1:0] quo;
  logic [CB-1:0] dsor;
  logic [CB:0]   trial;
  logic [CB:0]   diff;
  logic          ge;

  // Multiplier.
  logic [YW-1:0] mcand;
  logic [YW-1:0] acc;
  logic [MB-1:0] mplier;

  logic [CNTW-1:0] cnt;

  // Walk.
  logic signed [AW-1:0] aq;
  logic        [IW-1:0] inc;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] xlim;
  logic        [YW-1:0] y;
  logic        [YW-1:0] ystep;
  logic                 found;

  logic signed [BW-1:0] bl_e;
  logic signed [BW-1:0] bt_e;
  logic signed [BW-1:0] bw_e;
  logic signed [BW-1:0] bh_e;
  logic signed [BW-1:0] m_e;
  logic signed [CB-1:0] xlo_in;
  logic signed [CB-1:0] xhi_in;
  logic signed [DW-1:0] adx_full;
  logic signed [DW-1:0] ady_full;
  logic        [CB-1:0] adx;
  logic        [CB-1:0] ady;
  logic                 aq_neg;
  logic signed [KW-1:0] px_k;
  logic signed [KW-1:0] py_k;
  logic signed [KW-1:0] l_k;
  logic signed [KW-1:0] r_k;
  logic signed [KW-1:0] t_k;
  logic signed [KW-1:0] b_k;
  logic                 vert_hit;

  assign bl_e   = BW'(box_left);
  assign bt_e   = BW'(box_top);
  assign bw_e   = signed'(BW'(box_width));
  assign bh_e   = signed'(BW'(box_height));
  assign m_e    = signed'(BW'(pen_width[7:1]));
  assign xlo_in = (end_x < start_x) ? end_x : start_x;
  assign xhi_in = (end_x < start_x) ? start_x : end_x;

  assign adx_full = dx[DW-1] ? -dx : dx;
  assign ady_full = dy[DW-1] ? -dy : dy;
  assign adx      = adx_full[CB-1:0];
  assign ady      = ady_full[CB-1:0];
  assign aq_neg   = dx[DW-1] ^ dy[DW-1];

  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, dsor};
  assign ge    = (trial >= {1'b0, dsor});

  // Rounded sample point: x carries the half already, y likewise.
  assign px_k = KW'(signed'(xr[XW-1:FB]));
  assign py_k = KW'(signed'(y[YW-1:2*FB]));
  assign l_k  = KW'(edge_l);
  assign r_k  = KW'(edge_r);
  assign t_k  = KW'(edge_t);
  assign b_k  = KW'(edge_b);

  // A vertical segment hits when x is inside and the two y spans overlap.
  assign vert_hit = (x1_b >= edge_l) && (x1_b <= edge_r) && (ylo <= edge_b) &&
                    (edge_t <= yhi) && (edge_t <= edge_b);

  assign status.vertical  = (dx == '0);
  assign status.x_rev     = dx[DW-1];
  assign status.need_inc  = (adx < ady);
  assign status.seq_done  = (cnt == '0);
  assign status.in_range  = (xr <= xlim);
  assign status.point_hit = (px_k >= l_k) && (px_k <= r_k) && (py_k >= t_k) && (py_k <= b_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      cnt <= CNTW'(NW);
    end else if (cmd.mul_start) begin
      cnt <= CNTW'(MB);
    end else if (cmd.div_step || cmd.mul_step) begin
      cnt <= cnt - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx     <= DW'(end_x) - DW'(start_x);
      dy     <= DW'(end_y) - DW'(start_y);
      edge_l <= bl_e - m_e;
      edge_r <= bl_e + bw_e + m_e - ONE_B;
      edge_t <= bt_e - m_e;
      edge_b <= bt_e + bh_e + m_e - ONE_B;
      x1_b   <= BW'(start_x);
      ylo    <= (end_y < start_y) ? BW'(end_y) : BW'(start_y);
      yhi    <= (end_y < start_y) ? BW'(start_y) : BW'(end_y);
      xr     <= (XW'(xlo_in) << FB) | XHALF;
      xlim   <= (XW'(xhi_in) << FB) | XHALF;
      y      <= (YW'(start_y) << (2 * FB)) | YHALF;
      inc    <= INC_ONE;
    end else if (cmd.take_off) begin
      // The walk starts at the far end, so back y off by slope times dx.
      y <= y - (acc << FB);
    end else if (cmd.take_inc) begin
      inc <= (quo == '0) ? IW'(1) : quo[IW-1:0];
    end else if (cmd.walk_step) begin
      xr <= xr + signed'(XW'(inc));
      y  <= y + ystep;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= '0;
      quo  <= cmd.div_inc ? {adx, {FB{1'b0}}} : {ady, {FB{1'b0}}};
      dsor <= cmd.div_inc ? ady : adx;
    end else if (cmd.div_step) begin
      rem <= ge ? diff[CB-1:0] : trial[CB-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_aq) begin
      aq <= aq_neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mcand  <= YW'(aq);
      mplier <= cmd.mul_inc ? MB'(inc) : MB'(adx);
      acc    <= '0;
    end else if (cmd.mul_step) begin
      acc    <= acc + (mplier[0] ? mcand : '0);
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_step) begin
      ystep <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found <= 1'b0;
    end else if (cmd.set_vert) begin
      found <= vert_hit;
    end else if (cmd.set_hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit <= found;
    end
  end

endmodule

>>> sv/segment_box_hit_test.sv
// Timing: a vertical segment goes straight from the check to the answer. Other segments
//   first run setup on the serial divider and multiplier (slope division, offset and
//   step products), then walk their samples one at a time.
// Queries: one at a time; a truncated step lets the walk visit up to
//   2*max(|dx|,|dy|)+1 samples. The answer waits in an output register meanwhile.
// Reset clears the controller and the output valid; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Segment box hit test: top level
// Decides whether a sampled segment touches a rectangle widened by half the pen.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_box_hit_test_defines.svh"

module segment_box_hit_test #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] box_left,
  input  logic signed [COORD_BITS-1:0] box_top,
  input  logic        [COORD_BITS-1:0] box_width,
  input  logic        [COORD_BITS-1:0] box_height,
  input  logic        [7:0]            pen_width,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit
);

  sbht_pkg::cmd_t    cmd;
  sbht_pkg::status_t status;

  sbht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sbht_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_width  (box_width),
    .box_height (box_height),
    .pen_width  (pen_width),
    .hit        (hit)
  );

  // A taken word keeps the block busy for at least the next cycle.
  `SBHT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "accepted word did not make the block busy")
  // The walk only advances past points that are in range and miss.
  `SBHT_ASSERT_IMP(a_walk_step_legal, clk, rst, cmd.walk_step, status.in_range && !status.point_hit, "walk advanced past a hit or beyond the end")
  // Divider and multiplier never iterate past their bit count.
  `SBHT_ASSERT_IMP(a_seq_no_overrun, clk, rst, cmd.div_step || cmd.mul_step, !status.seq_done, "serial unit stepped after completion")

endmodule

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// Segment box hit test: self-checking testbench
// Offers segment and rectangle queries over a valid/ready channel, predicts
// each hit answer with a fixed-point walk of its own, and compares every
// answer word in order. It covers directed corner cases, random phases with
// and without idling on either side, and a long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int COORD = 16;
  localparam int FRAC  = 16;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 300;

  typedef longint unsigned u64_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [COORD-1:0] start_x = '0;
  logic signed [COORD-1:0] start_y = '0;
  logic signed [COORD-1:0] end_x = '0;
  logic signed [COORD-1:0] end_y = '0;
  logic signed [COORD-1:0] box_left = '0;
  logic signed [COORD-1:0] box_top = '0;
  logic        [COORD-1:0] box_width = '0;
  logic        [COORD-1:0] box_height = '0;
  logic        [7:0]       pen_width = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    hit;

  bit expected_hits[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;
  bit want_hit;

  segment_box_hit_test #(
    .COORD_BITS(COORD),
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .box_left  (box_left),
    .box_top   (box_top),
    .box_width (box_width),
    .box_height(box_height),
    .pen_width (pen_width),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL segment_box_hit_test");
    $finish;
  end

  // Walks the segment exactly as the block does: Q16 slope and step, Q32 y.
  function automatic bit predict_hit(
    input logic signed [COORD-1:0] sx, sy, ex, ey, bl, bt,
    input logic [COORD-1:0] bw, bh,
    input logic [7:0] pw
  );
    longint x1, y1, x2, y2, left64, top64, w64, h64, mg;
    longint lft, rgt, top_e, bot_e, one, dx, dy, slope_q, adx, ady, step_q;
    longint xlo, xhi, xq, xend, x1q, px, py, ylo, yhi, lo, hi;
    u64_t ybase, yhalf, yw;
    bit found;
    x1 = sx;
    y1 = sy;
    x2 = ex;
    y2 = ey;
    left64 = bl;
    top64 = bt;
    w64 = bw;
    h64 = bh;
    mg = pw >> 1;
    lft = left64 - mg;
    rgt = left64 + w64 - 1 + mg;
    top_e = top64 - mg;
    bot_e = top64 + h64 - 1 + mg;
    found = 1'b0;
    if (x1 == x2) begin
      ylo = (y1 < y2) ? y1 : y2;
      yhi = (y1 < y2) ? y2 : y1;
      lo = (ylo > top_e) ? ylo : top_e;
      hi = (yhi < bot_e) ? yhi : bot_e;
      found = (x1 >= lft) && (x1 <= rgt) && (lo <= hi);
    end else begin
      one = longint'(1) << FRAC;
      dx = x2 - x1;
      dy = y2 - y1;
      slope_q = (dy * one) / dx;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      step_q = (adx < ady) ? (adx * one) / ady : one;
      if (step_q < 1) step_q = 1;
      xlo = (x1 < x2) ? x1 : x2;
      xhi = (x1 < x2) ? x2 : x1;
      xq = xlo * one;
      xend = xhi * one;
      x1q = x1 * one;
      ybase = u64_t'(y1) << (2 * FRAC);
      yhalf = u64_t'(1) << (2 * FRAC - 1);
      while (xq <= xend && !found) begin
        px = (xq + (one >>> 1)) >>> FRAC;
        yw = ybase + u64_t'(slope_q) * u64_t'(xq - x1q) + yhalf;
        py = $signed(yw) >>> (2 * FRAC);
        found = (px >= lft) && (px <= rgt) && (py >= top_e) && (py <= bot_e);
        xq = xq + step_q;
      end
    end
    return found;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Answers are retired before new queries are recorded, so the order within
  // one edge never matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("answer word hit=%0b with nothing outstanding", hit));
        end else begin
          want_hit = expected_hits.pop_front();
          if (hit !== want_hit) begin
            report_mismatch($sformatf("hit=%0b, predicted %0b", hit, want_hit));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_hits.push_back(predict_hit(start_x, start_y, end_x, end_y, box_left,
                                            box_top, box_width, box_height, pen_width));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request from a test.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_query(
    input int sx, sy, ex, ey, bl, bt, bw, bh, pw
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x <= COORD'(sx);
    start_y <= COORD'(sy);
    end_x <= COORD'(ex);
    end_y <= COORD'(ey);
    box_left <= COORD'(bl);
    box_top <= COORD'(bt);
    box_width <= COORD'(bw);
    box_height <= COORD'(bh);
    pen_width <= 8'(pw);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  task automatic random_query();
    int span, dx, dy, sx, sy, ex, ey, bl, bt, bw, bh, pw, frac;
    if ($urandom_range(99) < 2) span = $urandom_range(8000, 500);
    else span = $urandom_range(48, 1);
    sx = $urandom_range(65535) - 32768;
    sy = $urandom_range(65535) - 32768;
    dx = ($urandom_range(9) == 0) ? 0 : $urandom_range(2 * span) - span;
    dy = $urandom_range(2 * span) - span;
    ex = sx + dx;
    if (ex > 32767 || ex < -32768) ex = sx - dx;
    ey = sy + dy;
    if (ey > 32767 || ey < -32768) ey = sy - dy;
    if ($urandom_range(99) < 65) begin
      // Put a small box near some point of the segment so hits are common.
      frac = $urandom_range(100);
      bl = sx + (frac * (ex - sx)) / 100 - int'($urandom_range(20));
      bt = sy + (frac * (ey - sy)) / 100 - int'($urandom_range(20));
      bw = $urandom_range(40);
      bh = $urandom_range(40);
    end else begin
      bl = $urandom_range(65535) - 32768;
      bt = $urandom_range(65535) - 32768;
      bw = $urandom_range(65535);
      bh = $urandom_range(65535);
    end
    pw = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(12);
    send_query(sx, sy, ex, ey, bl, bt, bw, bh, pw);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Vertical segments, on and beside the box column.
    send_query(5, 0, 5, 10, 5, 5, 1, 1, 0);
    send_query(4, 0, 4, 10, 5, 5, 1, 1, 0);
    // Single points inside and outside.
    send_query(3, 3, 3, 3, 0, 0, 8, 8, 0);
    send_query(9, 9, 9, 9, 0, 0, 8, 8, 0);
    // Empty rectangles; a pen of two gives a margin that rescues one.
    send_query(0, 0, 10, 0, 5, 0, 0, 1, 0);
    send_query(0, 0, 10, 0, 5, 0, 0, 1, 1);
    send_query(0, 0, 10, 0, 5, 0, 0, 1, 2);
    send_query(2, -5, 2, 5, 0, 0, 8, 0, 0);
    send_query(-32768, 0, 32767, 0, -32768, -32768, 65535, 0, 0);
    // Shallow, steep, reversed and negative slopes.
    send_query(0, 0, 100, 7, 50, 3, 1, 1, 0);
    send_query(0, 0, 3, 200, 1, 100, 1, 1, 0);
    send_query(100, -50, -100, 50, 0, 0, 1, 1, 0);
    // A sample at exactly half a pixel rounds up.
    send_query(0, 0, 2, 1, 1, 1, 1, 1, 0);
    send_query(0, 0, 2, 1, 1, 0, 1, 1, 0);
    // Coordinate extremes and the widest box and pen.
    send_query(-32768, -32768, -32768, 32767, -32768, 32767, 1, 1, 0);
    send_query(32767, 32767, 32767, 32767, -32768, -32768, 65535, 65535, 255);
    send_query(32767, -32768, 32767, 0, 32767, -100, 65535, 1, 0);
    send_query(-32768, 32767, 32767, -32768, 0, 0, 65535, 65535, 254);
    // Full-length walks: a diagonal miss, a hit on the last sample, and a
    // near-vertical line whose step is a single fraction bit.
    send_query(-32768, -32768, 32767, 32767, -32768, 30000, 10, 10, 0);
    send_query(32767, 0, -32768, 0, 32767, 0, 1, 1, 0);
    send_query(0, -32768, 1, 32767, 100, 0, 1, 1, 0);
    wait_all_results();
  endtask

  task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) random_query();
    wait_all_results();
  endtask

  // The receiver holds off while queries keep coming, so the block fills up
  // and drops in_ready; afterwards the sender pauses for a full drain.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= ~hold_req;
    repeat (15) random_query();
    wait_all_results();
    send_idle_pct = 23;
    recv_stall_pct = 23;
    repeat (10) random_query();
    wait_all_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(140, 0, 0);
    test_random_phase(140, 67, 0);
    test_random_phase(140, 0, 67);
    test_output_hold();
    test_random_phase(140, 23, 23);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_hits.size() != 0) begin
      report_mismatch($sformatf("%0d answers never arrived", expected_hits.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS segment_box_hit_test");
    end else begin
      $display("FAIL segment_box_hit_test");
    end
    $finish;
  end

endmodule
